// File: rtl/lrutlb_pkg.sv
// Shared constants and types for the fully associative LRU translation buffer.
// No dependencies; used by rtl/lru_tlb_lookup.sv through scoped names.
package lrutlb_pkg;

  localparam int ENTRIES   = 16;
  localparam int PAGE_BITS = 20;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int CFG_W     = 5;
  localparam int TOT_W     = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [TOT_W-1:0]     tot_t;

  // Per-item lookup decision handed from the compare logic to the update logic.
  typedef struct packed {
    logic  hit;
    logic  use_free;
    logic  evict;
    idx_t  target;
    idx_t  old_rank;
    page_t evicted_page;
  } lookup_t;

endpackage

// File: rtl/lru_tlb_lookup.sv
// Top level of the fully associative LRU translation buffer lookup block.
// Depends on rtl/lrutlb_pkg.sv for constants and types.
//
// Each transaction is registered in the input stage and then, once the result side
// can take it, in the result register. Throughput: one lookup per cycle unless
// out_stall holds the result; all tags are compared in parallel and the recency ranks
// are updated in the same cycle, so the next item sees them at once.
// Reset (rst_n low, synchronous): the buffer is empty, counts are zero and the
// active entry limit returns to 16; no clearing pass is needed.
module lru_tlb_lookup (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lrutlb_pkg::PAGE_BITS-1:0]  in_page_number,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic                              out_evicted_valid,
  output logic [lrutlb_pkg::PAGE_BITS-1:0]  out_evicted_page,
  output logic [lrutlb_pkg::TOT_W-1:0]      out_hit_total,
  output logic [lrutlb_pkg::TOT_W-1:0]      out_miss_total,
  input  logic                              cfg_wr_en,
  input  logic [lrutlb_pkg::CFG_W-1:0]      cfg_wr_data
);

  // Configuration register holding the raw limit; it is clamped where used.
  logic [lrutlb_pkg::CFG_W-1:0] cfg_limit_r;

  // Input stage: one registered page number waiting for the lookup.
  logic               s1_vld_r;
  lrutlb_pkg::page_t  s1_page_r;
  logic               s1_adv;

  // Buffer state. Tags have no reset since a tag is only read while valid.
  lrutlb_pkg::page_t  tag_r   [lrutlb_pkg::ENTRIES];
  logic               valid_r [lrutlb_pkg::ENTRIES];
  lrutlb_pkg::idx_t   rank_r  [lrutlb_pkg::ENTRIES];
  lrutlb_pkg::cnt_t   vcnt_r;
  lrutlb_pkg::tot_t   hit_cnt_r;
  lrutlb_pkg::tot_t   miss_cnt_r;

  // Result register.
  logic               out_vld_r;
  logic               out_hit_r;
  logic               out_ev_vld_r;
  lrutlb_pkg::page_t  out_ev_page_r;

  lrutlb_pkg::lookup_t lk;
  lrutlb_pkg::cnt_t    limit;
  lrutlb_pkg::idx_t    last_rank;
  lrutlb_pkg::idx_t    match_idx;
  lrutlb_pkg::idx_t    free_idx;
  lrutlb_pkg::idx_t    victim_idx;
  logic                match_any;
  logic                victim_any;

  // The result register can take a new transaction when it is empty or being drained.
  // The input stage advances whenever it holds an item and the result side can take it.
  assign s1_adv   = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_adv;

  // Clamp the configured limit to the range 1..ENTRIES.
  always_comb begin
    if (cfg_limit_r == '0) begin
      limit = lrutlb_pkg::CNT_W'(1);
    end else if (32'(cfg_limit_r) > lrutlb_pkg::ENTRIES) begin
      limit = lrutlb_pkg::CNT_W'(lrutlb_pkg::ENTRIES);
    end else begin
      limit = lrutlb_pkg::CNT_W'(cfg_limit_r);
    end
  end

  // The ranks of the valid entries always form a permutation of 0..count-1, because
  // entries are only ever added and every update keeps ranks distinct. The least
  // recent entry is therefore the one whose rank equals count-1, found by a parallel
  // compare rather than a search for the maximum.
  always_comb begin
    logic [lrutlb_pkg::CNT_W-1:0] cnt_m1;
    cnt_m1    = vcnt_r - lrutlb_pkg::CNT_W'(1);
    last_rank = cnt_m1[lrutlb_pkg::IDX_W-1:0];
  end

  // Parallel tag compare and lowest-index priority selection for the hit, the first
  // free entry and the victim. The loops run downward so the lowest index wins.
  always_comb begin
    match_any  = 1'b0;
    match_idx  = '0;
    free_idx   = '0;
    victim_any = 1'b0;
    victim_idx = '0;
    for (int i = lrutlb_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (tag_r[i] == s1_page_r)) begin
        match_any = 1'b1;
        match_idx = lrutlb_pkg::IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = lrutlb_pkg::IDX_W'(i);
      end
      if (valid_r[i] && (rank_r[i] == last_rank)) begin
        victim_any = 1'b1;
        victim_idx = lrutlb_pkg::IDX_W'(i);
      end
    end
  end

  // Decide what this lookup does. A free entry exists whenever the valid count is
  // below the limit, since the limit never exceeds the number of entries.
  always_comb begin
    lk.hit          = match_any;
    lk.use_free     = !match_any && (vcnt_r < limit);
    lk.evict        = !match_any && !(vcnt_r < limit) && victim_any;
    lk.evicted_page = '0;
    if (match_any) begin
      lk.target   = match_idx;
      lk.old_rank = rank_r[match_idx];
    end else if (vcnt_r < limit) begin
      lk.target   = free_idx;
      lk.old_rank = '0;
    end else begin
      lk.target   = victim_idx;
      lk.old_rank = last_rank;
      if (victim_any) begin
        lk.evicted_page = tag_r[victim_idx];
      end
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_limit_r <= lrutlb_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_limit_r <= cfg_wr_data;
    end
  end

  // Input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_page_r <= in_page_number;
    end
  end

  // Recency, valid bits, valid count and saturating counters. The target becomes most
  // recent; on a fill every valid entry ages, otherwise only the entries that were
  // more recent than the target's old rank age.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lrutlb_pkg::ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= '0;
      end
      vcnt_r     <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else if (s1_adv) begin
      for (int i = 0; i < lrutlb_pkg::ENTRIES; i++) begin
        if (lrutlb_pkg::IDX_W'(i) == lk.target) begin
          if (lk.hit || lk.use_free || lk.evict) begin
            rank_r[i] <= '0;
          end
          if (lk.use_free) begin
            valid_r[i] <= 1'b1;
          end
        end else if (valid_r[i] && (lk.hit || lk.use_free || lk.evict) &&
                     (lk.use_free || (rank_r[i] < lk.old_rank))) begin
          rank_r[i] <= rank_r[i] + lrutlb_pkg::IDX_W'(1);
        end
      end
      if (lk.use_free) begin
        vcnt_r <= vcnt_r + lrutlb_pkg::CNT_W'(1);
      end
      if (lk.hit) begin
        if (hit_cnt_r != '1) begin
          hit_cnt_r <= hit_cnt_r + lrutlb_pkg::TOT_W'(1);
        end
      end else begin
        if (miss_cnt_r != '1) begin
          miss_cnt_r <= miss_cnt_r + lrutlb_pkg::TOT_W'(1);
        end
      end
    end
  end

  // Tag writes on a fill or a replacement.
  always_ff @(posedge clk) begin
    if (s1_adv && (lk.use_free || lk.evict)) begin
      tag_r[lk.target] <= s1_page_r;
    end
  end

  // Result register. The running totals are read straight from the counters, which
  // change only when the next transaction moves into this register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || !out_stall) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_hit_r     <= lk.hit;
      out_ev_vld_r  <= lk.evict;
      out_ev_page_r <= lk.evicted_page;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_hit           = out_hit_r;
  assign out_evicted_valid = out_ev_vld_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_hit_total     = hit_cnt_r;
  assign out_miss_total    = miss_cnt_r;

endmodule
